>>> design/bchd_pkg.sv
package bchd_pkg;

    localparam int BUTTON_W = 32;
    localparam int HOTKEY_W = 5;
    localparam int INDEX_W  = 2;

    localparam logic [BUTTON_W-1:0] BTN_2     = 32'h0000_0100;
    localparam logic [BUTTON_W-1:0] BTN_1     = 32'h0000_0200;
    localparam logic [BUTTON_W-1:0] BTN_B     = 32'h0000_0400;
    localparam logic [BUTTON_W-1:0] BTN_A     = 32'h0000_0800;
    localparam logic [BUTTON_W-1:0] BTN_MINUS = 32'h0000_1000;
    localparam logic [BUTTON_W-1:0] BTN_Z     = 32'h0000_2000;
    localparam logic [BUTTON_W-1:0] BTN_C     = 32'h0000_4000;

    localparam int MINUS_BIT = 12;

    localparam logic [HOTKEY_W-1:0] HK_SAVE         = 5'h01;
    localparam logic [HOTKEY_W-1:0] HK_RESTORE      = 5'h02;
    localparam logic [HOTKEY_W-1:0] HK_POWERUP      = 5'h04;
    localparam logic [HOTKEY_W-1:0] HK_RELOAD_START = 5'h08;
    localparam logic [HOTKEY_W-1:0] HK_RELOAD_HERE  = 5'h10;

    typedef struct packed {
        logic [BUTTON_W-1:0] prev_buttons;
        logic [HOTKEY_W-1:0] held;
        logic                chord_used;
        logic [BUTTON_W-1:0] suppress;
    } ctrl_state_t;

    localparam ctrl_state_t CTRL_STATE_RESET = '0;

endpackage

>>> design/bchd_step.sv
module bchd_step (
    input  bchd_pkg::ctrl_state_t                 state_cur,
    input  logic                                  sideways_layout,
    input  logic [bchd_pkg::BUTTON_W-1:0]         buttons,
    output bchd_pkg::ctrl_state_t                 state_new,
    output logic [bchd_pkg::BUTTON_W-1:0]         passed_buttons,
    output logic [bchd_pkg::HOTKEY_W-1:0]         hotkeys_pressed,
    output logic [bchd_pkg::HOTKEY_W-1:0]         hotkeys_held
);

    logic [bchd_pkg::BUTTON_W-1:0] chord_btn [3];
    logic [bchd_pkg::HOTKEY_W-1:0] chord_hk  [3];
    logic [bchd_pkg::BUTTON_W-1:0] restore_btn;

    always_comb
    begin
        if (sideways_layout)
        begin
            chord_btn[0] = bchd_pkg::BTN_1;
            chord_btn[1] = bchd_pkg::BTN_2;
            chord_btn[2] = bchd_pkg::BTN_A;
            restore_btn  = bchd_pkg::BTN_B;
        end
        else
        begin
            chord_btn[0] = bchd_pkg::BTN_B;
            chord_btn[1] = bchd_pkg::BTN_A;
            chord_btn[2] = bchd_pkg::BTN_Z;
            restore_btn  = bchd_pkg::BTN_C;
        end
        chord_hk[0] = bchd_pkg::HK_RELOAD_START;
        chord_hk[1] = bchd_pkg::HK_RELOAD_HERE;
        chord_hk[2] = bchd_pkg::HK_POWERUP;
    end

    always_comb
    begin
        state_new = state_cur;
        if ((buttons & bchd_pkg::BTN_MINUS) != '0)
        begin
            state_new.suppress = state_new.suppress | bchd_pkg::BTN_MINUS;
            for (int i = 0; i < 3; i++)
            begin
                if ((buttons & chord_btn[i]) != '0)
                begin
                    state_new.held       = state_new.held | chord_hk[i];
                    state_new.suppress   = state_new.suppress | chord_btn[i];
                    state_new.chord_used = 1'b1;
                end
                else
                begin
                    state_new.held = state_new.held & ~chord_hk[i];
                end
            end
        end
        else if ((state_cur.prev_buttons & bchd_pkg::BTN_MINUS) != '0)
        begin
            state_new.held = '0;
            if (state_cur.chord_used)
                state_new.chord_used = 1'b0;
            else
                state_new.held = bchd_pkg::HK_SAVE;
        end
        else
        begin
            state_new.held = state_new.held & ~bchd_pkg::HK_SAVE;
        end

        if ((buttons & restore_btn) != '0)
        begin
            state_new.held     = state_new.held | bchd_pkg::HK_RESTORE;
            state_new.suppress = state_new.suppress | restore_btn;
        end
        else
        begin
            state_new.held = state_new.held & ~bchd_pkg::HK_RESTORE;
        end

        state_new.prev_buttons = buttons;
        state_new.suppress     = state_new.suppress & buttons;
    end

    assign passed_buttons  = buttons & ~state_new.suppress;
    assign hotkeys_pressed = state_new.held & ~state_cur.held;
    assign hotkeys_held    = state_new.held;

endmodule

>>> design/button_chord_hotkey_decoder.sv
// Button chord hotkey decoder.
// Input channel (in_valid/in_ready): one poll of one controller per transaction,
// with controller_index, sideways_layout and the raw 32-bit buttons word.
// Output channel (out_valid/out_ready): one result per poll, in poll order,
// with passed_buttons, hotkeys_pressed and hotkeys_held.
// Per controller the block holds the previous buttons, the held hotkeys, a
// chord-used flag and a suppression mask in flip-flops.
// An accepted poll passes through the input register, then the result
// register, before it is presented on the output.
// Throughput: one poll per cycle while out_ready is high, also back to back on the
// same controller, since its state is updated as the result register loads.
// A poll whose index is NUM_CONTROLLERS or more passes buttons unchanged,
// reports no hotkeys and leaves all state alone.
// Reset clears all per-controller state and both valid flags.
// When the receiver stalls, the result register holds its transaction; the
// input register still takes one more poll, then in_ready drops until the
// output transaction completes.
module button_chord_hotkey_decoder #(
    parameter int NUM_CONTROLLERS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bchd_pkg::INDEX_W-1:0]  controller_index,
    input  logic                          sideways_layout,
    input  logic [bchd_pkg::BUTTON_W-1:0] buttons,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bchd_pkg::BUTTON_W-1:0] passed_buttons,
    output logic [bchd_pkg::HOTKEY_W-1:0] hotkeys_pressed,
    output logic [bchd_pkg::HOTKEY_W-1:0] hotkeys_held
);

    localparam int SEL_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
    localparam int CMP_W = 5;

    logic                          in_valid_reg;
    logic [bchd_pkg::INDEX_W-1:0]  index_reg;
    logic                          side_reg;
    logic [bchd_pkg::BUTTON_W-1:0] btn_reg;

    logic                          out_valid_reg;
    logic [bchd_pkg::BUTTON_W-1:0] passed_reg;
    logic [bchd_pkg::HOTKEY_W-1:0] pressed_reg;
    logic [bchd_pkg::HOTKEY_W-1:0] held_reg;

    bchd_pkg::ctrl_state_t         state_reg [NUM_CONTROLLERS];
    bchd_pkg::ctrl_state_t         state_next;

    logic [CMP_W-1:0]              index_ext;
    logic                          hit;
    logic [SEL_W-1:0]              sel;
    logic                          advance;

    logic [bchd_pkg::BUTTON_W-1:0] step_passed;
    logic [bchd_pkg::HOTKEY_W-1:0] step_pressed;
    logic [bchd_pkg::HOTKEY_W-1:0] step_held;

    assign index_ext = {{(CMP_W - bchd_pkg::INDEX_W){1'b0}}, index_reg};
    assign hit       = (index_ext < CMP_W'(NUM_CONTROLLERS));
    assign sel       = index_ext[SEL_W-1:0];
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    bchd_step u_step (
        .state_cur       (state_reg[sel]),
        .sideways_layout (side_reg),
        .buttons         (btn_reg),
        .state_new       (state_next),
        .passed_buttons  (step_passed),
        .hotkeys_pressed (step_pressed),
        .hotkeys_held    (step_held)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            index_reg <= controller_index;
            side_reg  <= sideways_layout;
            btn_reg   <= buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (hit)
            begin
                passed_reg  <= step_passed;
                pressed_reg <= step_pressed;
                held_reg    <= step_held;
            end
            else
            begin
                passed_reg  <= btn_reg;
                pressed_reg <= '0;
                held_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CONTROLLERS; i++)
                state_reg[i] <= bchd_pkg::CTRL_STATE_RESET;
        end
        else if (advance && hit)
        begin
            state_reg[sel] <= state_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign passed_buttons  = passed_reg;
    assign hotkeys_pressed = pressed_reg;
    assign hotkeys_held    = held_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both stages are full and stalled");

    a_miss_passes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !hit |=> hotkeys_held == '0 && hotkeys_pressed == '0
            && passed_buttons == $past(btn_reg))
        else $error("out-of-range poll altered its result");

    a_passed_subset: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (passed_buttons & ~$past(btn_reg)) == '0)
        else $error("passed buttons not a subset of polled buttons");

    a_pressed_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hotkeys_pressed & ~hotkeys_held) == '0)
        else $error("pressed hotkey not held");

    a_minus_suppressed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && hit && btn_reg[bchd_pkg::MINUS_BIT]
            |=> !passed_buttons[bchd_pkg::MINUS_BIT])
        else $error("minus passed through while held");

endmodule

>>> sim/button_chord_hotkey_decoder_test.sv
`timescale 1ns / 100ps

module button_chord_hotkey_decoder_test;

    localparam int NCTRL = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 160;
    localparam int BW = bchd_pkg::BUTTON_W;
    localparam int HW = bchd_pkg::HOTKEY_W;
    localparam int IW = bchd_pkg::INDEX_W;
    localparam logic [BW-1:0] KEYS = bchd_pkg::BTN_2 | bchd_pkg::BTN_1 | bchd_pkg::BTN_B
                                     | bchd_pkg::BTN_A | bchd_pkg::BTN_MINUS
                                     | bchd_pkg::BTN_Z | bchd_pkg::BTN_C;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic          side;
        logic [BW-1:0] btns;
    } poll_t;

    typedef struct packed {
        logic [BW-1:0] passed;
        logic [HW-1:0] pressed;
        logic [HW-1:0] held;
    } hotkey_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [IW-1:0] controller_index = '0;
    logic          sideways_layout = 1'b0;
    logic [BW-1:0] buttons = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [BW-1:0] passed_buttons;
    logic [HW-1:0] hotkeys_pressed;
    logic [HW-1:0] hotkeys_held;

    button_chord_hotkey_decoder #(
        .NUM_CONTROLLERS(NCTRL)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .controller_index(controller_index),
        .sideways_layout(sideways_layout),
        .buttons(buttons),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .passed_buttons(passed_buttons),
        .hotkeys_pressed(hotkeys_pressed),
        .hotkeys_held(hotkeys_held)
    );

    poll_t          pending_polls[$];
    hotkey_result_t expected_results[$];
    poll_t          cur_poll;

    logic [BW-1:0] prev_btn[NCTRL];
    logic [HW-1:0] held_hk[NCTRL];
    logic          chord_flag[NCTRL];
    logic [BW-1:0] supp_mask[NCTRL];
    logic          layout_of[NCTRL];

    int mismatches = 0;
    int polls_queued = 0;
    int polls_sent = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int long_holds = 0;
    int press_tally[HW];
    int burst_left = 0;
    int gap_left = 0;
    int stretch_left = 0;
    int ready_mode = 0;
    int hold_left = 0;
    int taken = 0;
    logic [7:0] ready_pat = 8'hFF;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [BW-1:0] got,
                                   input logic [BW-1:0] want);
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want,
                 results_checked);
        mismatches++;
    endtask

    task automatic apply_chord(input int c, input logic [BW-1:0] btns,
                               input logic [BW-1:0] button,
                               input logic [HW-1:0] hk);
        if ((btns & button) != 0)
        begin
            held_hk[c] |= hk;
            supp_mask[c] |= button;
            chord_flag[c] = 1'b1;
        end
        else
        begin
            held_hk[c] &= ~hk;
        end
    endtask

    task automatic predict_poll(input poll_t p);
        int c;
        logic [HW-1:0] prior;
        logic [BW-1:0] restore_btn;
        hotkey_result_t r;
        c = int'(p.idx);
        if (c >= NCTRL)
        begin
            r.passed = p.btns;
            r.pressed = '0;
            r.held = '0;
        end
        else
        begin
            prior = held_hk[c];
            if ((p.btns & bchd_pkg::BTN_MINUS) != 0)
            begin
                supp_mask[c] |= bchd_pkg::BTN_MINUS;
                if (p.side)
                begin
                    apply_chord(c, p.btns, bchd_pkg::BTN_1, bchd_pkg::HK_RELOAD_START);
                    apply_chord(c, p.btns, bchd_pkg::BTN_2, bchd_pkg::HK_RELOAD_HERE);
                    apply_chord(c, p.btns, bchd_pkg::BTN_A, bchd_pkg::HK_POWERUP);
                end
                else
                begin
                    apply_chord(c, p.btns, bchd_pkg::BTN_B, bchd_pkg::HK_RELOAD_START);
                    apply_chord(c, p.btns, bchd_pkg::BTN_A, bchd_pkg::HK_RELOAD_HERE);
                    apply_chord(c, p.btns, bchd_pkg::BTN_Z, bchd_pkg::HK_POWERUP);
                end
            end
            else if ((prev_btn[c] & bchd_pkg::BTN_MINUS) != 0)
            begin
                held_hk[c] = '0;
                if (chord_flag[c])
                    chord_flag[c] = 1'b0;
                else
                    held_hk[c] |= bchd_pkg::HK_SAVE;
            end
            else
            begin
                held_hk[c] &= ~bchd_pkg::HK_SAVE;
            end
            restore_btn = p.side ? bchd_pkg::BTN_B : bchd_pkg::BTN_C;
            if ((p.btns & restore_btn) != 0)
            begin
                held_hk[c] |= bchd_pkg::HK_RESTORE;
                supp_mask[c] |= restore_btn;
            end
            else
            begin
                held_hk[c] &= ~bchd_pkg::HK_RESTORE;
            end
            prev_btn[c] = p.btns;
            supp_mask[c] &= p.btns;
            r.passed = p.btns & ~supp_mask[c];
            r.pressed = held_hk[c] & ~prior;
            r.held = held_hk[c];
        end
        for (int b = 0; b < HW; b++)
            if (r.pressed[b])
                press_tally[b]++;
        expected_results.push_back(r);
    endtask

    task automatic push_poll(input int idx, input logic side, input logic [BW-1:0] btns);
        poll_t p;
        p.idx = IW'(idx);
        p.side = side;
        p.btns = btns;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    function automatic logic [BW-1:0] noise_bits();
        if ($urandom_range(0, 2) == 0)
            return $urandom & ~KEYS;
        return '0;
    endfunction

    function automatic logic [BW-1:0] chord_set(input logic side);
        return side ? (bchd_pkg::BTN_1 | bchd_pkg::BTN_2 | bchd_pkg::BTN_A)
                    : (bchd_pkg::BTN_B | bchd_pkg::BTN_A | bchd_pkg::BTN_Z);
    endfunction

    task automatic add_random(input int count);
        int target;
        int idx;
        int k;
        logic side;
        logic [BW-1:0] extra;
        target = polls_queued + count;
        while (polls_queued < target)
        begin
            idx = $urandom_range(0, NCTRL - 1);
            if ($urandom_range(0, 15) == 0)
                layout_of[idx] = ~layout_of[idx];
            side = layout_of[idx];
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    k = $urandom_range(1, 4);
                    for (int i = 0; i < k; i++)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            extra = '0;
                        else
                            extra = $urandom & chord_set(side);
                        if ($urandom_range(0, 3) == 0)
                            extra |= $urandom & (bchd_pkg::BTN_B | bchd_pkg::BTN_C);
                        push_poll(idx, side, bchd_pkg::BTN_MINUS | extra | noise_bits());
                    end
                    push_poll(idx, side, ($urandom & KEYS & ~bchd_pkg::BTN_MINUS &
                              {BW{$urandom_range(0, 1) == 1}}) | noise_bits());
                    if ($urandom_range(0, 1) == 0)
                        push_poll(idx, side, noise_bits());
                end
                6, 7: push_poll(idx, side, ($urandom & KEYS & ~bchd_pkg::BTN_MINUS)
                                           | noise_bits());
                8: push_poll(idx, side, $urandom);
                default:
                begin
                    push_poll(idx, side, bchd_pkg::BTN_MINUS | ($urandom & KEYS));
                    push_poll(idx, ~side, $urandom & KEYS);
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_polls.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: bursts of polls separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            controller_index <= '0;
            sideways_layout <= 1'b0;
            buttons <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_poll(cur_poll);
                polls_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (burst_left != 0 && pending_polls.size() != 0)
                begin
                    cur_poll = pending_polls.pop_front();
                    controller_index <= cur_poll.idx;
                    sideways_layout <= cur_poll.side;
                    buttons <= cur_poll.btns;
                    in_valid <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (burst_left == 0)
                    begin
                        if (gap_left != 0)
                        begin
                            gap_left--;
                        end
                        else
                        begin
                            burst_left = ($urandom_range(0, 7) == 0) ? 200
                                         : $urandom_range(1, 32);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0
                                       : $urandom_range(1, 10);
                        end
                    end
                end
            end
        end
    end

    // Receiver: stretches of always-ready, random and patterned stalls, plus long holds.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            taken = 0;
            hold_left = 0;
            stretch_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                taken++;
            if (hold_left == 0 && long_holds < 2 && taken >= (long_holds + 1) * 350)
            begin
                hold_left = LONG_HOLD;
                long_holds++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(10, 80);
                    ready_mode = $urandom_range(0, 2);
                    ready_pat = 8'($urandom) | 8'h01;
                end
                stretch_left--;
                case (ready_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 2) != 0);
                    default: out_ready <= ready_pat[stretch_left[2:0]];
                endcase
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        hotkey_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", passed_buttons, '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (passed_buttons !== want.passed)
                    report_mismatch("passed_buttons", passed_buttons, want.passed);
                if (hotkeys_pressed !== want.pressed)
                    report_mismatch("hotkeys_pressed", BW'(hotkeys_pressed),
                                    BW'(want.pressed));
                if (hotkeys_held !== want.held)
                    report_mismatch("hotkeys_held", BW'(hotkeys_held), BW'(want.held));
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("button_chord_hotkey_decoder regression: fail");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < NCTRL; c++)
        begin
            prev_btn[c] = '0;
            held_hk[c] = '0;
            chord_flag[c] = 1'b0;
            supp_mask[c] = '0;
            layout_of[c] = c[0];
        end
        for (int b = 0; b < HW; b++)
            press_tally[b] = 0;

        push_poll(0, 1'b1, 32'h0000_0000);
        push_poll(3, 1'b0, 32'hFFFF_FFFF);
        push_poll(1, 1'b1, 32'hFFFF_FFFF);
        push_poll(0, 1'b1, bchd_pkg::BTN_MINUS);
        push_poll(0, 1'b1, 32'h0000_0000);
        push_poll(0, 1'b1, bchd_pkg::BTN_MINUS);
        push_poll(0, 1'b1, bchd_pkg::BTN_MINUS | bchd_pkg::BTN_1);
        push_poll(0, 1'b1, bchd_pkg::BTN_MINUS | bchd_pkg::BTN_1 | bchd_pkg::BTN_2
                           | bchd_pkg::BTN_A);
        push_poll(0, 1'b1, bchd_pkg::BTN_1);
        push_poll(0, 1'b1, 32'h0000_0000);
        push_poll(2, 1'b0, bchd_pkg::BTN_MINUS | bchd_pkg::BTN_B);
        push_poll(2, 1'b0, bchd_pkg::BTN_MINUS | bchd_pkg::BTN_A | bchd_pkg::BTN_Z);
        push_poll(2, 1'b0, bchd_pkg::BTN_Z);
        push_poll(2, 1'b0, 32'h0000_0000);
        push_poll(1, 1'b1, bchd_pkg::BTN_B);
        push_poll(1, 1'b0, bchd_pkg::BTN_C);
        push_poll(1, 1'b0, bchd_pkg::BTN_C | bchd_pkg::BTN_B);
        push_poll(3, 1'b1, bchd_pkg::BTN_MINUS | 32'h8000_0001);
        push_poll(3, 1'b1, 32'h8000_0001);
        push_poll(3, 1'b1, 32'h0000_0000);
        push_poll(0, 1'b0, 32'hAAAA_AAAA);
        push_poll(0, 1'b0, 32'h5555_5555);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        add_random(515);
        wait_drained();
        add_random(515);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d polls over %0d cycles, %0d results checked, %0d long receiver holds.",
                 polls_sent, cycle_count, results_checked, long_holds);
        $display("Hotkey presses seen: save %0d, restore %0d, powerup %0d, %s %0d, %s %0d.",
                 press_tally[0], press_tally[1], press_tally[2],
                 "reload start", press_tally[3], "reload here", press_tally[4]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("button_chord_hotkey_decoder regression: pass");
        else
            $display("button_chord_hotkey_decoder regression: fail");
        $finish;
    end

endmodule
